@@ src/apfc_pkg.sv @@
// apfc_pkg: constants and types shared by the ack packet framer
// no dependencies; used by every module of the framer
`timescale 1ns / 1ps
`default_nettype none

package apfc_pkg;

    // tunnel payload bytes per packet
    localparam int TUNNEL_BYTES = 96;

    // packet constants
    localparam logic [31:0] SYNC_WORD   = 32'h1D01A5A5;
    localparam logic [15:0] SEQ_FLAGS   = 16'hC000;
    localparam logic [4:0]  ID_TOP      = 5'b00011;
    localparam logic [15:0] BODY_LEN_M1 = 16'(TUNNEL_BYTES + 25);
    localparam logic [31:0] CRC_POLY    = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT    = 32'hFFFFFFFF;
    localparam logic [10:0] APID_RESET  = 11'd101;

    // configuration register indexes
    localparam logic CFG_MAGIC = 1'b0;
    localparam logic CFG_APID  = 1'b1;

    // stream widths
    localparam int IN_DATA_W = 144;
    localparam int CFG_W     = 11;

    // byte positions within the emission of one item
    localparam int HDR_BYTES   = 14;
    localparam int BODY_BYTES  = 20;
    localparam int SEQ_LEN     = 41;
    localparam int POS_W       = 6;
    localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(HDR_BYTES + BODY_BYTES);
    localparam logic [POS_W-1:0] POS_CRC     = POS_W'(HDR_BYTES + BODY_BYTES + 3);
    localparam logic [POS_W-1:0] POS_END     = POS_W'(SEQ_LEN - 1);

    // payload counter width
    localparam int IDX_W = (TUNNEL_BYTES > 1) ? $clog2(TUNNEL_BYTES) : 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(TUNNEL_BYTES - 1);

    // one accepted input transfer
    typedef struct packed {
        logic [31:0] duration_value;
        logic [31:0] frequency_value;
        logic [15:0] elevation_value;
        logic [15:0] azimuth_value;
        logic [7:0]  ack_status;
        logic [31:0] target_id;
        logic [7:0]  payload_byte;
    } item_t;

endpackage

`default_nettype wire

@@ src/apfc_crc_byte.sv @@
// apfc_crc_byte: one-byte update of the reflected crc-32 register
// depends on apfc_pkg for the polynomial
`timescale 1ns / 1ps
`default_nettype none

module apfc_crc_byte
(
    input  wire logic [31:0] crc_in,
    input  wire logic [7:0]  data,
    output logic [31:0]      crc_out
);

    // eight bit steps of the lsb-first shift register
    always_comb
    begin
        logic [31:0] c;
        c = crc_in ^ {24'h0, data};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ apfc_pkg::CRC_POLY) : (c >> 1);
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

@@ src/ack_packet_framer_crc32_top.sv @@
// ack_packet_framer_crc32_top: serializes ack packets with header, body and crc-32
// depends on apfc_pkg and apfc_crc_byte
// first output byte passes the item holding register and the output byte register
// throughput: one output byte per cycle while an item is held and m_tready high;
// a middle payload item emits one byte, a packet's first item 35 and its last 7,
// all through the single output byte register; 136 bytes per 96 inputs
// reset: rst_n clears counters, valid flags; crc to ones; config magic 0, apid 101
`timescale 1ns / 1ps
`default_nettype none

module ack_packet_framer_crc32_top
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // payload_byte, target_id, ack_status, azimuth_value, elevation_value,
    // frequency_value, duration_value
    input  wire logic [apfc_pkg::IN_DATA_W-1:0] s_tdata,
    // output stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [7:0]                         m_tdata,   // out_byte
    output logic                               m_tlast,   // packet_end
    // configuration writes
    input  wire logic                          cfg_we,
    input  wire logic                          cfg_index,
    input  wire logic [apfc_pkg::CFG_W-1:0]    cfg_wdata
);

    logic [7:0]                  magic_reg;
    logic [10:0]                 apid_reg;
    apfc_pkg::item_t             item_reg;
    logic                        item_valid_reg;
    logic                        item_last_reg;
    logic [apfc_pkg::POS_W-1:0]  pos_reg;
    logic [apfc_pkg::POS_W-1:0]  pos_next;
    logic [apfc_pkg::IDX_W-1:0]  idx_reg;
    logic [31:0]                 crc_reg;
    logic [31:0]                 crc_base;
    logic [31:0]                 crc_next;
    logic [7:0]                  out_data_reg;
    logic                        out_last_reg;
    logic                        out_valid_reg;
    logic                        in_fire;
    logic                        emit_fire;
    logic                        emit_final;
    logic                        acc_first;
    logic                        acc_last;
    logic [7:0]                  seq_byte [0:apfc_pkg::SEQ_LEN-1];
    logic [111:0]                hdr;
    logic [159:0]                body;
    logic [31:0]                 crc_out;

    // handshakes
    assign emit_fire  = item_valid_reg && (!out_valid_reg || m_tready);
    assign emit_final = (pos_reg == apfc_pkg::POS_END) ||
                        ((pos_reg == apfc_pkg::POS_PAYLOAD) && !item_last_reg);
    assign s_tready   = !item_valid_reg || (emit_fire && emit_final);
    assign in_fire    = s_tvalid && s_tready;

    assign acc_first = (idx_reg == '0);
    assign acc_last  = (idx_reg == apfc_pkg::IDX_LAST);

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg <= '0;
            apid_reg  <= apfc_pkg::APID_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                apfc_pkg::CFG_MAGIC: magic_reg <= cfg_wdata[7:0];
                apfc_pkg::CFG_APID:  apid_reg  <= cfg_wdata[10:0];
                default:             magic_reg <= magic_reg;
            endcase
        end
    end

    // packet byte sequence for the held item
    assign hdr  = {apfc_pkg::SYNC_WORD, apfc_pkg::ID_TOP, apid_reg,
                   apfc_pkg::SEQ_FLAGS, apfc_pkg::BODY_LEN_M1, 32'h0};
    assign body = {item_reg.duration_value, item_reg.frequency_value,
                   item_reg.elevation_value, item_reg.azimuth_value, 8'h0,
                   item_reg.ack_status, item_reg.target_id, 8'h0, magic_reg};
    assign crc_out = ~crc_reg;

    always_comb
    begin
        for (int k = 0; k < apfc_pkg::HDR_BYTES; k++)
        begin
            seq_byte[k] = hdr[8*(apfc_pkg::HDR_BYTES-1-k) +: 8];
        end
        for (int k = 0; k < apfc_pkg::BODY_BYTES; k++)
        begin
            seq_byte[apfc_pkg::HDR_BYTES+k] = body[8*k +: 8];
        end
        seq_byte[apfc_pkg::POS_PAYLOAD]      = item_reg.payload_byte;
        seq_byte[apfc_pkg::POS_PAYLOAD + 1]  = 8'h0;
        seq_byte[apfc_pkg::POS_PAYLOAD + 2]  = 8'h0;
        for (int k = 0; k < 4; k++)
        begin
            seq_byte[apfc_pkg::POS_CRC + k] = crc_out[8*k +: 8];
        end
    end

    // running crc over covered bytes
    assign crc_base = (pos_reg == '0) ? apfc_pkg::CRC_INIT : crc_reg;

    apfc_crc_byte u_crc
    (
        .crc_in  (crc_base),
        .data    (seq_byte[pos_reg]),
        .crc_out (crc_next)
    );

    // next emission position, held at the final byte of an item
    always_comb
    begin
        pos_next = pos_reg;
        if (in_fire)
        begin
            pos_next = acc_first ? '0 : apfc_pkg::POS_PAYLOAD;
        end
        else if (emit_fire && !emit_final)
        begin
            pos_next = pos_reg + 1'b1;
        end
    end

    // item holding register and sequencing control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            pos_reg        <= '0;
            idx_reg        <= '0;
            crc_reg        <= apfc_pkg::CRC_INIT;
            item_last_reg  <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            if (in_fire)
            begin
                item_valid_reg <= 1'b1;
                item_last_reg  <= acc_last;
                idx_reg        <= acc_last ? '0 : idx_reg + 1'b1;
            end
            else if (emit_fire && emit_final)
            begin
                item_valid_reg <= 1'b0;
            end
            if (emit_fire && (pos_reg < apfc_pkg::POS_CRC))
            begin
                crc_reg <= crc_next;
            end
        end
    end

    // payload of the held item
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg <= apfc_pkg::item_t'(s_tdata);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_fire)
        begin
            out_data_reg <= seq_byte[pos_reg];
            out_last_reg <= (pos_reg == apfc_pkg::POS_END);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

@@ src/apfc_checker.sv @@
// apfc_checker: port-level assertions for the ack packet framer
// depends on ack_packet_framer_crc32_top ports; bound to the top level below
`timescale 1ns / 1ps
`default_nettype none

module apfc_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       s_tvalid,
    input wire logic       s_tready,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // a stalled output transfer holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
        else $error("output transfer changed while stalled");

    // packet end never repeats on consecutive output bytes
    a_end_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && m_tlast) |=> !(m_tvalid && m_tlast))
        else $error("packet end on consecutive bytes");

    // a blocked input can only open once the output moves again
    a_ready_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && !s_tready) |=> (!s_tready || m_tready))
        else $error("input ready rose during output stall");

    // the output stays valid when a stall meets a blocked, waiting input
    a_no_accept_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && !s_tready && s_tvalid) |=> (m_tvalid))
        else $error("output dropped during stall");

endmodule

bind ack_packet_framer_crc32_top apfc_checker u_apfc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

@@ tb/ack_packet_framer_crc32_top_tb.sv @@
// ack_packet_framer_crc32_top_tb: self-checking bench for the ack packet framer
// depends on apfc_pkg and ack_packet_framer_crc32_top; the frame predictor lives in a
// small scoreboard class, random stream stalls on both sides, register changes between runs
`timescale 1ns / 1ps

module ack_packet_framer_crc32_top_tb;

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          SETTLE_TICKS = 4;
    localparam int          TAIL_TICKS   = 20;
    localparam logic [15:0] ID_BASE      = 16'h1800;

    // one expected output byte
    typedef struct {
        logic [7:0] data;
        logic       last;
    } frame_byte_t;

    // frame predictor and store of expected frame bytes
    class frame_scoreboard;
        logic [7:0]   magic;
        logic [10:0]  apid;
        int unsigned  taken;
        logic [31:0]  crc;
        frame_byte_t  expected_q[$];
        int           errors;

        function new();
            magic  = 8'h00;
            apid   = apfc_pkg::APID_RESET;
            taken  = 0;
            crc    = apfc_pkg::CRC_INIT;
            errors = 0;
        endfunction

        function void write_reg(logic idx, logic [apfc_pkg::CFG_W-1:0] value);
            if (idx == apfc_pkg::CFG_MAGIC)
                magic = value[7:0];
            else
                apid = value[10:0];
        endfunction

        function int outstanding();
            return expected_q.size();
        endfunction

        // queue one byte; covered bytes go through the reflected crc
        function void push_byte(logic [7:0] b, bit covered, bit last);
            frame_byte_t e;
            int k;
            e.data = b;
            e.last = last;
            expected_q.push_back(e);
            if (covered)
            begin
                crc = crc ^ {24'h0, b};
                for (k = 0; k < 8; k++)
                    crc = crc[0] ? ((crc >> 1) ^ apfc_pkg::CRC_POLY) : (crc >> 1);
            end
        endfunction

        function void push_le(logic [31:0] v, int nbytes);
            int k;
            for (k = 0; k < nbytes; k++)
                push_byte(v[8*k +: 8], 1'b1, 1'b0);
        endfunction

        function void push_be(logic [31:0] v, int nbytes);
            int k;
            for (k = nbytes - 1; k >= 0; k--)
                push_byte(v[8*k +: 8], 1'b1, 1'b0);
        endfunction

        // note one accepted input transfer and predict its bytes
        function void note_input(apfc_pkg::item_t it);
            logic [31:0] fcs;
            int k;
            if (taken == 0)
            begin
                // header, big endian
                crc = apfc_pkg::CRC_INIT;
                push_be(apfc_pkg::SYNC_WORD, 4);
                push_be({16'h0, ID_BASE | {5'd0, apid}}, 2);
                push_be({16'h0, apfc_pkg::SEQ_FLAGS}, 2);
                push_be(32'(apfc_pkg::TUNNEL_BYTES + 25), 2);
                push_be(32'h0, 4);
                // body fields, little endian
                push_byte(magic, 1'b1, 1'b0);
                push_byte(8'h00, 1'b1, 1'b0);
                push_le(it.target_id, 4);
                push_byte(it.ack_status, 1'b1, 1'b0);
                push_byte(8'h00, 1'b1, 1'b0);
                push_le({16'h0, it.azimuth_value}, 2);
                push_le({16'h0, it.elevation_value}, 2);
                push_le(it.frequency_value, 4);
                push_le(it.duration_value, 4);
            end
            push_byte(it.payload_byte, 1'b1, 1'b0);
            taken++;
            // trailer: pad then inverted crc, lsb first
            if (taken >= apfc_pkg::TUNNEL_BYTES)
            begin
                push_byte(8'h00, 1'b1, 1'b0);
                push_byte(8'h00, 1'b1, 1'b0);
                fcs = ~crc;
                for (k = 0; k < 4; k++)
                    push_byte(fcs[8*k +: 8], 1'b0, k == 3);
                taken = 0;
                crc   = apfc_pkg::CRC_INIT;
            end
        endfunction

        // compare one output transfer with the oldest expected byte
        function void check_output(logic [7:0] data, logic last);
            frame_byte_t e;
            if (expected_q.size() == 0)
            begin
                $display("%0t: unexpected output byte, expected none, actual %02h last %b",
                         $time, data, last);
                errors++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (e.data !== data)
                begin
                    $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                             $time, e.data, data);
                    errors++;
                end
                if (e.last !== last)
                begin
                    $display("%0t: packet_end mismatch, expected %b, actual %b",
                             $time, e.last, last);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    // payload_byte, target_id, ack_status, azimuth_value,
    // elevation_value, frequency_value, duration_value
    logic [apfc_pkg::IN_DATA_W-1:0]  s_tdata;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [7:0]                      m_tdata;    // out_byte
    logic                            m_tlast;    // packet_end
    logic                            cfg_we;
    logic                            cfg_index;
    logic [apfc_pkg::CFG_W-1:0]      cfg_wdata;

    frame_scoreboard       sb = new();
    bit                    no_gaps = 1'b0;
    int                    cycles = 0;

    ack_packet_framer_crc32_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // scalar fields random, only sampled on the first byte of a packet
    function automatic apfc_pkg::item_t random_item(logic [7:0] b);
        apfc_pkg::item_t it;
        it.payload_byte    = b;
        it.target_id       = $urandom();
        it.ack_status      = 8'($urandom());
        it.azimuth_value   = 16'($urandom());
        it.elevation_value = 16'($urandom());
        it.frequency_value = $urandom();
        it.duration_value  = $urandom();
        return it;
    endfunction

    // one input transfer after a random gap
    task automatic send_item(apfc_pkg::item_t it);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        do @(posedge clk); while (s_tready !== 1'b1);
        sb.note_input(it);
    endtask

    task automatic send_random(int count);
        int i;
        for (i = 0; i < count; i++)
        begin
            if (i % 32 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            send_item(random_item(8'($urandom())));
        end
    endtask

    // stop sending and wait for every expected byte
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic set_regs(logic [apfc_pkg::CFG_W-1:0] magic_val,
                            logic [apfc_pkg::CFG_W-1:0] apid_val);
        cfg_we    <= 1'b1;
        cfg_index <= apfc_pkg::CFG_MAGIC;
        cfg_wdata <= magic_val;
        @(posedge clk);
        sb.write_reg(apfc_pkg::CFG_MAGIC, magic_val);
        cfg_index <= apfc_pkg::CFG_APID;
        cfg_wdata <= apid_val;
        @(posedge clk);
        sb.write_reg(apfc_pkg::CFG_APID, apid_val);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // output side: random stalls, check every transfer
    initial
    begin : rx_side
        int stall;
        m_tready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = no_gaps ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            sb.check_output(m_tdata, m_tlast);
        end
    end

    // stimulus
    initial
    begin : tx_side
        apfc_pkg::item_t first;
        int k;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= apfc_pkg::CFG_MAGIC;
        cfg_wdata <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // packet with reset register values: all-ones fields, then byte patterns
        first = '1;
        send_item(first);
        send_item(random_item(8'h00));
        for (k = 0; k < 8; k++)
            send_item(random_item(8'h01 << k));
        for (k = 0; k < 8; k++)
            send_item(random_item(~(8'h01 << k)));
        send_item(random_item(8'h55));
        send_item(random_item(8'hAA));
        send_random(apfc_pkg::TUNNEL_BYTES - 20);

        // upper register values, all-zero fields; unused magic bits set
        settle();
        set_regs(11'h7FF, 11'h7FF);
        first = '0;
        send_item(first);
        send_random(apfc_pkg::TUNNEL_BYTES - 1);

        // zero registers, then a change halfway that only shows in the next packet
        settle();
        set_regs(11'h000, 11'h000);
        send_random(apfc_pkg::TUNNEL_BYTES / 2);
        settle();
        set_regs(11'($urandom()), 11'($urandom()));
        send_random(apfc_pkg::TUNNEL_BYTES - apfc_pkg::TUNNEL_BYTES / 2);

        // part of one more packet
        send_random(32);

        settle();
        repeat (TAIL_TICKS) @(posedge clk);
        if (sb.errors == 0 && sb.outstanding() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
